@@ rtl/atke_pkg.sv @@
// shared types, constants and the base encoder for the anchor/target k-mer extractor
package atke_pkg;

  localparam int MAX_KMER  = 32;
  localparam int LEN_W     = 6;
  localparam int BASE_W    = 8;
  localparam int KMER_W    = 64;
  localparam int POS_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd27;
  localparam logic [POS_W-1:0] POS_MAX   = 7'd127;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LENGTH = 1'b1;

  // one window slot: 2-bit code and its invalid mark
  typedef struct packed {
    logic       bad;
    logic [1:0] code;
  } sym_t;

  function automatic sym_t encode_base(input logic [BASE_W-1:0] b);
    sym_t s;
    s.bad  = 1'b0;
    s.code = 2'd0;
    unique case (b)
      8'h41, 8'h61: s.code = 2'd0;
      8'h43, 8'h63: s.code = 2'd1;
      8'h47, 8'h67: s.code = 2'd2;
      8'h54, 8'h74: s.code = 2'd3;
      default:      s.bad  = 1'b1;
    endcase
    return s;
  endfunction

  // zero acts as one, above the maximum acts as the maximum
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] max_len);
    logic [LEN_W-1:0] r;
    priority if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > max_len) begin
      r = max_len;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/anchor_target_kmer_extractor.sv @@
// top level of the anchor/target k-mer extractor: window cell chain, k-mer taps, output buffer
//
// usage:
//   s_axis carries one sequence character per request: tdata[7:0] is the raw byte, tuser
//   marks the first character of a new read. A, C, G, T in either case are valid symbols.
//   m_axis carries one result per qualifying character: tdata[63:0] anchor k-mer,
//   tdata[127:64] target k-mer (zero when the target holds an invalid symbol), tuser the
//   target valid flag. k-mers are packed 2 bits per symbol, oldest symbol most significant.
//   cfg_we_i with cfg_idx_i writes anchor length (index 0) or target length (index 1);
//   lengths are clamped to 1..MAX_KMER; the user writes them only while idle (not enforced).
// timing:
//   one character per cycle sustained while s_axis_tready is high; a result is registered
//   in the output buffer when its character is taken. The cost per item is set by the single
//   shift of the cell chain and the variable anchor tap.
// reset:
//   clears the window cells, the read position and the output buffer; lengths return to 27.
// stall:
//   a two-entry output buffer (output register plus skid) holds results; s_axis_tready
//   drops only once both entries are full, and only characters are held, none are lost.
module anchor_target_kmer_extractor #(
  parameter int MAX_KMER = atke_pkg::MAX_KMER
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [atke_pkg::BASE_W-1:0]      s_axis_tdata,   // [7:0] base
  input  logic                             s_axis_tuser,   // [0] read_start
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [2*atke_pkg::KMER_W-1:0]    m_axis_tdata,   // [63:0] anchor_kmer, [127:64] target_kmer
  output logic                             m_axis_tuser,   // [0] target_valid
  input  logic                             cfg_we_i,
  input  logic [atke_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [atke_pkg::LEN_W-1:0]       cfg_wdata_i
);

  localparam int WIN    = 2 * MAX_KMER;
  localparam int IDX_W  = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int LEN_W  = atke_pkg::LEN_W;
  localparam int POS_W  = atke_pkg::POS_W;
  localparam int KMER_W = atke_pkg::KMER_W;
  localparam int RES_W  = 2 * KMER_W + 1;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_KMER);

  logic [LEN_W-1:0] anchor_len_q, target_len_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             accept;
  atke_pkg::sym_t   new_sym;
  atke_pkg::sym_t   win [WIN];

  logic [LEN_W-1:0]  alen, tlen;
  logic [LEN_W:0]    total;
  logic [KMER_W-1:0] anchor_kmer, target_kmer;
  logic              anchor_ok, target_ok, emit;
  logic [RES_W-1:0]  res_in, res_out;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign new_sym = atke_pkg::encode_base(s_axis_tdata);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_len_q <= atke_pkg::LEN_RESET;
      target_len_q <= atke_pkg::LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atke_pkg::CFG_ANCHOR_LENGTH: anchor_len_q <= cfg_wdata_i;
        atke_pkg::CFG_TARGET_LENGTH: target_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // read position, saturating
  always_comb begin
    pos_d = s_axis_tuser ? '0 : pos_q;
    if (pos_d != atke_pkg::POS_MAX) begin
      pos_d = pos_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  // window chain, cell 0 holds the newest symbol
  for (genvar i = 0; i < WIN; i++) begin : g_cell
    atke_pkg::sym_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = new_sym;
    end else begin : g_link
      assign cell_in = win[i-1];
    end
    atke_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .sym_i   (cell_in),
      .sym_o   (win[i])
    );
  end

  assign alen  = atke_pkg::clamp_len(anchor_len_q, MaxLen);
  assign tlen  = atke_pkg::clamp_len(target_len_q, MaxLen);
  assign total = {1'b0, alen} + {1'b0, tlen};

  // taps taken from the window as it stands after this shift: slot k is old cell k-1
  always_comb begin
    logic [LEN_W:0] a_idx;
    anchor_kmer = '0;
    target_kmer = '0;
    anchor_ok   = 1'b1;
    target_ok   = !new_sym.bad;
    target_kmer[1:0] = new_sym.code;
    for (int j = 0; j < MAX_KMER; j++) begin
      a_idx = {1'b0, tlen} - 1'b1 + (LEN_W+1)'(j);
      if ((LEN_W+1)'(j) < {1'b0, alen}) begin
        anchor_kmer[2*j +: 2] = win[a_idx[IDX_W-1:0]].code;
        if (win[a_idx[IDX_W-1:0]].bad) begin
          anchor_ok = 1'b0;
        end
      end
    end
    for (int j = 1; j < MAX_KMER; j++) begin
      if ((LEN_W+1)'(j) < {1'b0, tlen}) begin
        target_kmer[2*j +: 2] = win[j-1].code;
        if (win[j-1].bad) begin
          target_ok = 1'b0;
        end
      end
    end
    if (!target_ok) begin
      target_kmer = '0;
    end
  end

  // total and the read position share one width
  assign emit   = accept && anchor_ok && (total <= pos_d);
  assign res_in = {target_ok, target_kmer, anchor_kmer};

  atke_out_buf #(
    .W (RES_W)
  ) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (res_in),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (res_out),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = res_out[2*KMER_W-1:0];
  assign m_axis_tuser = res_out[RES_W-1];

endmodule

@@ rtl/atke_cell.sv @@
// one window cell: holds a symbol and passes it to the next cell on each accepted request
module atke_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  atke_pkg::sym_t  sym_i,
  output atke_pkg::sym_t  sym_o
);

  atke_pkg::sym_t sym_q, sym_d;

  always_comb begin
    sym_d = shift_i ? sym_i : sym_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= '0;
    end else begin
      sym_q <= sym_d;
    end
  end

  assign sym_o = sym_q;

endmodule

@@ rtl/atke_out_buf.sv @@
// output register with a skid stage so the input side keeps flowing under a stall
module atke_out_buf #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         ready_o,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  input  logic         ready_i
);

  logic         out_v_q, out_v_d;
  logic         skid_v_q, skid_v_d;
  logic [W-1:0] out_q, out_d;
  logic [W-1:0] skid_q, skid_d;
  logic         out_fire;

  assign out_fire = out_v_q && ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (out_fire) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_v_q || out_fire) begin
        out_d   = data_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = data_i;
        skid_v_d = 1'b1;
      end
    end else if (out_fire) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

@@ sim/anchor_target_kmer_extractor_tb.sv @@
// testbench for the anchor/target k-mer extractor: directed reads, random reads, stalls
`timescale 1ns / 100ps

module anchor_target_kmer_extractor_tb;

  localparam int MAX_KMER  = atke_pkg::MAX_KMER;
  localparam int KMER_W    = atke_pkg::KMER_W;
  localparam int BASE_W    = atke_pkg::BASE_W;
  localparam int LEN_W     = atke_pkg::LEN_W;
  localparam int POS_W     = atke_pkg::POS_W;
  localparam int CFG_IDX_W = atke_pkg::CFG_IDX_W;

  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int WIN_DEPTH    = 2 * MAX_KMER;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [1:0] SYM_A = 2'd0;
  localparam logic [1:0] SYM_C = 2'd1;
  localparam logic [1:0] SYM_G = 2'd2;
  localparam logic [1:0] SYM_T = 2'd3;

  typedef struct packed {
    logic [KMER_W-1:0] anchor;
    logic [KMER_W-1:0] target;
    logic              tvalid;
  } kmer_pair_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [BASE_W-1:0]     s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [2*KMER_W-1:0]   m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [LEN_W-1:0]      cfg_wdata_i;

  // predictor state
  logic [1:0]            win_code [WIN_DEPTH];
  bit                    win_bad  [WIN_DEPTH];
  logic [POS_W-1:0]      read_pos;
  logic [LEN_W-1:0]      anchor_len_reg;
  logic [LEN_W-1:0]      target_len_reg;
  kmer_pair_t            pending_kmers[$];
  kmer_pair_t            exp_pair;

  int                    err_cnt;
  int                    quiet_cycles;
  int                    rx_hold_cycles;
  bit                    tx_idle_en;
  bit                    rx_idle_en;

  anchor_target_kmer_extractor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int effective_len(input logic [LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_KMER) return MAX_KMER;
    return int'(v);
  endfunction

  // shift one character into the window and queue the k-mer pair it yields, if any
  function automatic void predict_kmers(input logic [BASE_W-1:0] b, input logic start);
    int         alen;
    int         tlen;
    int         total;
    int         idx;
    logic [1:0] code;
    bit         bad;
    kmer_pair_t r;
    alen  = effective_len(anchor_len_reg);
    tlen  = effective_len(target_len_reg);
    total = alen + tlen;
    bad   = 1'b0;
    case (b)
      "A", "a": code = SYM_A;
      "C", "c": code = SYM_C;
      "G", "g": code = SYM_G;
      "T", "t": code = SYM_T;
      default: begin
        code = SYM_A;
        bad  = 1'b1;
      end
    endcase
    if (start) read_pos = '0;
    for (int i = WIN_DEPTH - 1; i > 0; i--) begin
      win_code[i] = win_code[i-1];
      win_bad[i]  = win_bad[i-1];
    end
    win_code[0] = code;
    win_bad[0]  = bad;
    if (read_pos < atke_pkg::POS_MAX) read_pos = read_pos + 1'b1;
    if (int'(read_pos) < total) return;
    r = '0;
    r.tvalid = 1'b1;
    for (int i = 0; i < alen; i++) begin
      idx = total - 1 - i;
      if (win_bad[idx]) return;
      r.anchor = {r.anchor[KMER_W-3:0], win_code[idx]};
    end
    for (int i = 0; i < tlen; i++) begin
      idx = tlen - 1 - i;
      if (win_bad[idx]) r.tvalid = 1'b0;
      r.target = {r.target[KMER_W-3:0], win_code[idx]};
    end
    if (!r.tvalid) r.target = '0;
    pending_kmers.insert(pending_kmers.size(), r);
  endfunction

  // output check first, then register writes, then the new character
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_kmers.size() == 0) begin
          $error("result with none expected: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          err_cnt++;
        end else begin
          exp_pair = pending_kmers.pop_front();
          if (m_axis_tdata[KMER_W-1:0] !== exp_pair.anchor) begin
            $error("anchor_kmer mismatch: expected %h, got %h",
                   exp_pair.anchor, m_axis_tdata[KMER_W-1:0]);
            err_cnt++;
          end
          if (m_axis_tdata[2*KMER_W-1:KMER_W] !== exp_pair.target) begin
            $error("target_kmer mismatch: expected %h, got %h",
                   exp_pair.target, m_axis_tdata[2*KMER_W-1:KMER_W]);
            err_cnt++;
          end
          if (m_axis_tuser !== exp_pair.tvalid) begin
            $error("target_valid mismatch: expected %b, got %b",
                   exp_pair.tvalid, m_axis_tuser);
            err_cnt++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          atke_pkg::CFG_ANCHOR_LENGTH: anchor_len_reg = cfg_wdata_i;
          atke_pkg::CFG_TARGET_LENGTH: target_len_reg = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_kmers(s_axis_tdata, s_axis_tuser);

      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: long hold-off on demand, otherwise random stalls while rx_idle_en is set
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cycles--;
    end else if (rx_idle_en && $urandom_range(99) < 10) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_base(input logic [BASE_W-1:0] b, input logic start);
    while (tx_idle_en && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_string(input string s, input bit start);
    for (int i = 0; i < s.len(); i++) send_base(s[i], start && i == 0);
  endtask

  task automatic send_random_read(input int len, input int bad_pct, input bit start);
    string            valid_chars;
    logic [BASE_W-1:0] b;
    valid_chars = "ACGTacgt";
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < bad_pct) b = BASE_W'($urandom_range(255));
      else b = valid_chars[$urandom_range(7)];
      send_base(b, start && i == 0);
    end
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_kmers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lengths(input logic [LEN_W-1:0] alen, input logic [LEN_W-1:0] tlen);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= atke_pkg::CFG_ANCHOR_LENGTH;
    cfg_wdata_i <= alen;
    @(posedge clk_i);
    cfg_idx_i   <= atke_pkg::CFG_TARGET_LENGTH;
    cfg_wdata_i <= tlen;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [LEN_W-1:0] alen, input logic [LEN_W-1:0] tlen,
                                  input int n_items, input int bad_pct);
    int total;
    int sent;
    int len;
    write_lengths(alen, tlen);
    total = effective_len(alen) + effective_len(tlen);
    sent  = 0;
    while (sent < n_items) begin
      // mostly reads long enough to yield results, some cut short
      if ($urandom_range(9) < 2) len = $urandom_range(total, 1);
      else len = total + $urandom_range(40);
      send_random_read(len, bad_pct, $urandom_range(9) != 0);
      sent += len;
    end
  endtask

  // read continuing from reset without a start flag, lengths at their reset values
  task automatic test_reset_lengths();
    send_random_read(70, 2, 1'b0);
  endtask

  task automatic test_directed_cases();
    write_lengths(6'd2, 6'd2);
    send_string("ACGTNac", 1'b1);   // bad symbol walks from target into anchor
    send_string("aCg", 1'b1);       // too short for any result
    send_base(8'h00, 1'b1);
    send_base(8'hFF, 1'b0);
    send_string("tGcA", 1'b0);
    send_string("tgca", 1'b1);
    write_lengths(6'd0, 6'd0);      // zero lengths act as one
    send_string("GTc", 1'b1);
  endtask

  // window full length, read long enough to saturate the position, no idling at all
  task automatic test_long_read();
    write_lengths(6'd63, 6'd40);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_read(160, 0, 1'b1);
    wait_results_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_backpressure();
    write_lengths(6'd3, 6'd2);
    rx_hold_cycles = HOLD_CYCLES;
    send_random_read(60, 0, 1'b1);
    wait_results_drained();
    send_random_read(40, 5, 1'b1);
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = atke_pkg::CFG_ANCHOR_LENGTH;
    cfg_wdata_i    = '0;
    anchor_len_reg = atke_pkg::LEN_RESET;
    target_len_reg = atke_pkg::LEN_RESET;
    read_pos       = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_code[i] = SYM_A;
      win_bad[i]  = 1'b0;
    end
    err_cnt        = 0;
    quiet_cycles   = 0;
    rx_hold_cycles = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_lengths();
    test_directed_cases();
    run_random_phase(6'd1, 6'd1, 40, 10);
    test_long_read();
    run_random_phase(6'd63, 6'd0, 30, 10);
    run_random_phase(6'd0, 6'd63, 30, 10);
    test_output_backpressure();
    run_random_phase(6'd4, 6'd7, 80, 15);
    run_random_phase(6'd9, 6'd5, 40, 25);

    wait_results_drained();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
